// ----- sv/tpid_pkg.sv -----
// Types, constants and codes shared by the temperature PID step block.
package tpid_pkg;

    localparam int ERR_W      = 18;
    localparam int DIFF_W     = 19;
    localparam int LEAK_SHIFT = 20;
    localparam int MA_W       = LEAK_SHIFT + 1;
    localparam int MB_W       = 17;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int INTEG_W    = 40;
    localparam int SUM_W      = 42;
    localparam int DNUM_W     = 39;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MB_W-1:0] LEAK_NUM   = 17'd10486;
    localparam int              OFFSET_DEG = 3;
    localparam logic [7:0]      DUTY_MAX   = 8'd255;

    localparam logic signed [SUM_W-1:0] INTEG_MAX = (42'sd1 <<< (INTEG_W - 1)) - 42'sd1;
    localparam logic signed [SUM_W-1:0] INTEG_MIN = -(42'sd1 <<< (INTEG_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 2'd3;

    localparam logic [1:0] MA_ERR  = 2'd0;
    localparam logic [1:0] MA_XHI  = 2'd1;
    localparam logic [1:0] MA_XLO  = 2'd2;
    localparam logic [1:0] MA_DIFF = 2'd3;

    localparam logic [1:0] MB_KP   = 2'd0;
    localparam logic [1:0] MB_KI   = 2'd1;
    localparam logic [1:0] MB_KD   = 2'd2;
    localparam logic [1:0] MB_LEAK = 2'd3;

    localparam logic [1:0] XLD_NONE  = 2'd0;
    localparam logic [1:0] XLD_MUL   = 2'd1;
    localparam logic [1:0] XLD_INTEG = 2'd2;

    localparam logic [2:0] ACC_NONE      = 3'd0;
    localparam logic [2:0] ACC_ADD_PROD  = 3'd1;
    localparam logic [2:0] ACC_ADD_SHR   = 3'd2;
    localparam logic [2:0] ACC_ADD_INTEG = 3'd3;
    localparam logic [2:0] ACC_ADD_DIV   = 3'd4;

    localparam logic [1:0] IACC_NONE      = 2'd0;
    localparam logic [1:0] IACC_LOAD_PROD = 2'd1;
    localparam logic [1:0] IACC_ADD_SHR   = 2'd2;
    localparam logic [1:0] IACC_SAT       = 2'd3;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [15:0]        elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] pwm_level;
    } t_out;

    typedef struct packed {
        logic       load;
        logic [1:0] ma_sel;
        logic [1:0] mb_sel;
        logic       prod_en;
        logic [1:0] x_ld;
        logic [2:0] acc_op;
        logic [1:0] iacc_op;
        logic       d_load;
        logic       div_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic ms_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- sv/tpid_div.sv -----
// Bit-serial restoring divider: unsigned magnitude over the elapsed milliseconds.
module tpid_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tpid_pkg::DNUM_W-1:0]    i_num,
    input  logic [15:0]                    i_den,
    output logic [tpid_pkg::DNUM_W-1:0]    o_quo,
    output logic                           o_done
);

    logic [tpid_pkg::DNUM_W-1:0]    r_quo;
    logic [15:0]                    r_rem;
    logic [tpid_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [16:0]                    w_trial;
    logic                           w_ge;

    assign w_trial = {r_rem, r_quo[tpid_pkg::DNUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tpid_pkg::DIV_CNT_W'(tpid_pkg::DNUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tpid_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[tpid_pkg::DNUM_W-2:0], w_ge};
            r_rem <= w_ge ? 16'(w_trial - {1'b0, i_den}) : w_trial[15:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("divider done while busy");

endmodule

// ----- sv/tpid_dp.sv -----
// Datapath: configuration, shared multiplier, accumulators, divider and result register.
module tpid_dp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tpid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tpid_pkg::t_in                      i_in_data,
    input  tpid_pkg::t_cmd                     i_cmd,
    output tpid_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tpid_pkg::t_out                     o_out_data
);

    localparam logic signed [tpid_pkg::ERR_W-1:0] OFFSET =
        tpid_pkg::ERR_W'(tpid_pkg::OFFSET_DEG * (1 << FRAC_BITS));
    localparam int SUM_SHIFT = 2 * FRAC_BITS;

    logic signed [15:0]                    r_setpoint;
    logic [15:0]                           r_kp;
    logic [15:0]                           r_ki;
    logic [15:0]                           r_kd;
    logic signed [tpid_pkg::ERR_W-1:0]     r_err;
    logic signed [tpid_pkg::ERR_W-1:0]     r_last_err;
    logic [15:0]                           r_ms;
    logic signed [tpid_pkg::INTEG_W-1:0]   r_integ;
    logic signed [tpid_pkg::INTEG_W-1:0]   r_x;
    logic signed [tpid_pkg::PROD_W-1:0]    r_prod;
    logic signed [tpid_pkg::SUM_W-1:0]     r_acc;
    logic signed [tpid_pkg::SUM_W-1:0]     r_iacc;
    logic                                  r_dnum_neg;
    logic [tpid_pkg::DNUM_W-1:0]           r_dnum_mag;
    logic                                  r_out_valid;
    tpid_pkg::t_out                        r_out;

    logic signed [tpid_pkg::ERR_W-1:0]     w_err;
    logic signed [tpid_pkg::DIFF_W-1:0]    w_diff;
    logic signed [tpid_pkg::MA_W-1:0]      w_ma;
    logic signed [tpid_pkg::MB_W-1:0]      w_mb;
    logic signed [tpid_pkg::PROD_W-1:0]    w_mul;
    logic signed [tpid_pkg::SUM_W-1:0]     w_prod_shr;
    logic signed [tpid_pkg::SUM_W-1:0]     w_isum;
    logic signed [tpid_pkg::DNUM_W-1:0]    w_d1;
    logic signed [tpid_pkg::DNUM_W-1:0]    w_d10;
    logic [tpid_pkg::DNUM_W-1:0]           w_quo;
    logic                                  w_div_done;
    logic signed [tpid_pkg::SUM_W-1:0]     w_qs;
    logic signed [tpid_pkg::SUM_W-1:0]     w_dval;
    logic [tpid_pkg::SUM_W-1:0]            w_whole;
    logic [7:0]                            w_duty;

    assign w_err  = tpid_pkg::ERR_W'(r_setpoint) - tpid_pkg::ERR_W'(i_in_data.temperature)
                    + OFFSET;
    assign w_diff = tpid_pkg::DIFF_W'(r_err) - tpid_pkg::DIFF_W'(r_last_err);

    always_comb begin
        unique case (i_cmd.ma_sel)
            tpid_pkg::MA_ERR:  w_ma = tpid_pkg::MA_W'(r_err);
            tpid_pkg::MA_XHI:  w_ma = tpid_pkg::MA_W'(
                                   $signed(r_x[tpid_pkg::INTEG_W-1:tpid_pkg::LEAK_SHIFT]));
            tpid_pkg::MA_XLO:  w_ma = $signed({1'b0, r_x[tpid_pkg::LEAK_SHIFT-1:0]});
            tpid_pkg::MA_DIFF: w_ma = tpid_pkg::MA_W'(w_diff);
            default:           w_ma = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.mb_sel)
            tpid_pkg::MB_KP:   w_mb = $signed({1'b0, r_kp});
            tpid_pkg::MB_KI:   w_mb = $signed({1'b0, r_ki});
            tpid_pkg::MB_KD:   w_mb = $signed({1'b0, r_kd});
            tpid_pkg::MB_LEAK: w_mb = $signed(tpid_pkg::LEAK_NUM);
            default:           w_mb = '0;
        endcase
    end

    assign w_mul = w_ma * w_mb;

    assign w_prod_shr = tpid_pkg::SUM_W'(
        $signed({1'b0, r_prod[tpid_pkg::PROD_W-1:tpid_pkg::LEAK_SHIFT]}));
    assign w_isum = r_iacc + tpid_pkg::SUM_W'(r_prod);
    assign w_d1   = tpid_pkg::DNUM_W'(r_prod);
    assign w_d10  = (w_d1 <<< 3) + (w_d1 <<< 1);
    assign w_qs   = $signed(tpid_pkg::SUM_W'(w_quo));
    assign w_dval = r_dnum_neg ? -w_qs : w_qs;

    tpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_dnum_mag),
        .i_den   (r_ms),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // config registers and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tpid_pkg::CFG_SETPOINT: r_setpoint <= $signed(i_cfg_data);
                    tpid_pkg::CFG_KP:       r_kp       <= i_cfg_data;
                    tpid_pkg::CFG_KI:       r_ki       <= i_cfg_data;
                    tpid_pkg::CFG_KD:       r_kd       <= i_cfg_data;
                    default:                r_kd       <= r_kd;
                endcase
            end
            if (i_cmd.iacc_op == tpid_pkg::IACC_SAT) begin
                if (w_isum > tpid_pkg::INTEG_MAX) begin
                    r_integ <= tpid_pkg::INTEG_W'(tpid_pkg::INTEG_MAX);
                end else if (w_isum < tpid_pkg::INTEG_MIN) begin
                    r_integ <= tpid_pkg::INTEG_W'(tpid_pkg::INTEG_MIN);
                end else begin
                    r_integ <= tpid_pkg::INTEG_W'(w_isum);
                end
            end
            if (i_cmd.d_load) begin
                r_last_err <= r_err;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= w_err;
            r_ms  <= i_in_data.elapsed_ms;
        end
        if (i_cmd.prod_en) begin
            r_prod <= w_mul;
        end
        unique case (i_cmd.x_ld)
            tpid_pkg::XLD_MUL:   r_x <= tpid_pkg::INTEG_W'(w_mul);
            tpid_pkg::XLD_INTEG: r_x <= r_integ;
            default:             r_x <= r_x;
        endcase
        if (i_cmd.load) begin
            r_acc <= '0;
        end else begin
            unique case (i_cmd.acc_op)
                tpid_pkg::ACC_ADD_PROD:  r_acc <= r_acc + tpid_pkg::SUM_W'(r_prod);
                tpid_pkg::ACC_ADD_SHR:   r_acc <= r_acc + w_prod_shr;
                tpid_pkg::ACC_ADD_INTEG: r_acc <= r_acc + tpid_pkg::SUM_W'(r_integ);
                tpid_pkg::ACC_ADD_DIV:   r_acc <= r_acc + w_dval;
                default:                 r_acc <= r_acc;
            endcase
        end
        unique case (i_cmd.iacc_op)
            tpid_pkg::IACC_LOAD_PROD: r_iacc <= tpid_pkg::SUM_W'(r_prod);
            tpid_pkg::IACC_ADD_SHR:   r_iacc <= r_iacc + w_prod_shr;
            default:                  r_iacc <= r_iacc;
        endcase
        if (i_cmd.d_load) begin
            r_dnum_neg <= w_d10[tpid_pkg::DNUM_W-1];
            r_dnum_mag <= w_d10[tpid_pkg::DNUM_W-1] ? tpid_pkg::DNUM_W'(-w_d10)
                                                    : tpid_pkg::DNUM_W'(w_d10);
        end
    end

    assign w_whole = r_acc >> SUM_SHIFT;

    always_comb begin
        priority if (r_acc[tpid_pkg::SUM_W-1]) begin
            w_duty = '0;
        end else if (w_whole > tpid_pkg::SUM_W'(tpid_pkg::DUTY_MAX)) begin
            w_duty = tpid_pkg::DUTY_MAX;
        end else begin
            w_duty = w_whole[7:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.duty      <= w_duty;
            r_out.pwm_level <= tpid_pkg::DUTY_MAX - w_duty;
        end
    end

    assign o_status.ms_zero  = (r_ms == '0);
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    a_pwm_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duty + o_out_data.pwm_level == tpid_pkg::DUTY_MAX))
        else $error("pwm level is not the inverse of duty");

endmodule

// ----- sv/tpid_ctrl.sv -----
// Controller: sequences the multiplier, accumulators and divider for each transaction.
module tpid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tpid_pkg::t_status i_status,
    output tpid_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MKP  = 4'd1;
    localparam logic [3:0] ST_PH   = 4'd2;
    localparam logic [3:0] ST_PL   = 4'd3;
    localparam logic [3:0] ST_PSUM = 4'd4;
    localparam logic [3:0] ST_IH   = 4'd5;
    localparam logic [3:0] ST_IL   = 4'd6;
    localparam logic [3:0] ST_ISUM = 4'd7;
    localparam logic [3:0] ST_ISAT = 4'd8;
    localparam logic [3:0] ST_D10  = 4'd9;
    localparam logic [3:0] ST_DIVS = 4'd10;
    localparam logic [3:0] ST_DIVW = 4'd11;
    localparam logic [3:0] ST_DADD = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MKP;
                end
            end
            ST_MKP: begin
                o_cmd.ma_sel = tpid_pkg::MA_ERR;
                o_cmd.mb_sel = tpid_pkg::MB_KP;
                o_cmd.x_ld   = tpid_pkg::XLD_MUL;
                n_state      = ST_PH;
            end
            ST_PH: begin
                o_cmd.ma_sel  = tpid_pkg::MA_XHI;
                o_cmd.mb_sel  = tpid_pkg::MB_LEAK;
                o_cmd.prod_en = 1'b1;
                n_state       = ST_PL;
            end
            ST_PL: begin
                o_cmd.ma_sel  = tpid_pkg::MA_XLO;
                o_cmd.mb_sel  = tpid_pkg::MB_LEAK;
                o_cmd.prod_en = 1'b1;
                o_cmd.acc_op  = tpid_pkg::ACC_ADD_PROD;
                n_state       = ST_PSUM;
            end
            ST_PSUM: begin
                o_cmd.acc_op = tpid_pkg::ACC_ADD_SHR;
                o_cmd.x_ld   = tpid_pkg::XLD_INTEG;
                n_state      = ST_IH;
            end
            ST_IH: begin
                o_cmd.ma_sel  = tpid_pkg::MA_XHI;
                o_cmd.mb_sel  = tpid_pkg::MB_LEAK;
                o_cmd.prod_en = 1'b1;
                n_state       = ST_IL;
            end
            ST_IL: begin
                o_cmd.ma_sel  = tpid_pkg::MA_XLO;
                o_cmd.mb_sel  = tpid_pkg::MB_LEAK;
                o_cmd.prod_en = 1'b1;
                o_cmd.iacc_op = tpid_pkg::IACC_LOAD_PROD;
                n_state       = ST_ISUM;
            end
            ST_ISUM: begin
                o_cmd.ma_sel  = tpid_pkg::MA_ERR;
                o_cmd.mb_sel  = tpid_pkg::MB_KI;
                o_cmd.prod_en = 1'b1;
                o_cmd.iacc_op = tpid_pkg::IACC_ADD_SHR;
                n_state       = ST_ISAT;
            end
            ST_ISAT: begin
                o_cmd.ma_sel  = tpid_pkg::MA_DIFF;
                o_cmd.mb_sel  = tpid_pkg::MB_KD;
                o_cmd.prod_en = 1'b1;
                o_cmd.iacc_op = tpid_pkg::IACC_SAT;
                n_state       = ST_D10;
            end
            ST_D10: begin
                o_cmd.acc_op = tpid_pkg::ACC_ADD_INTEG;
                o_cmd.d_load = 1'b1;
                n_state      = i_status.ms_zero ? ST_OUT : ST_DIVS;
            end
            ST_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_status.div_done) begin
                    n_state = ST_DADD;
                end
            end
            ST_DADD: begin
                o_cmd.acc_op = tpid_pkg::ACC_ADD_DIV;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == ST_DIVW))
        else $error("divider finished outside its wait state");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result register overwritten before it was taken");

endmodule

// ----- sv/temperature_pid_step.sv -----
// Top level of the temperature PID step block.
// One transaction in gives one duty and inverted PWM level out. The result is
// loaded into the output register once that register is free; when elapsed_ms
// is zero the divider is skipped, otherwise the controller starts it and waits
// for its done strobe. Nine sequencing steps, seven of them on one shared 21x17
// multiplier, form the P, leaky I and D products. The derivative quotient
// comes from a bit-serial divider that resolves one of its 39 quotient bits
// per cycle. Items are handled one at a time; a finished result sits in an
// output register, so the next item is taken while it waits. Configuration
// writes go directly into the configuration registers.
module temperature_pid_step #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tpid_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tpid_pkg::t_out                  o_out_data
);

    tpid_pkg::t_cmd    w_cmd;
    tpid_pkg::t_status w_status;

    tpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tpid_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for temperature_pid_step against a PID predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      FRAC         = 8;
    localparam longint  PCT_MUL      = 10486;
    localparam int      PCT_SHIFT    = 20;
    localparam longint  DERIV_GAIN   = 10;
    localparam longint  TEMP_OFFSET  = 3;
    localparam longint  DUTY_TOP     = 255;
    localparam longint  INTEG_HI     = 64'sd549755813887;
    localparam longint  INTEG_LO     = -INTEG_HI - 1;
    localparam int      DRAIN_CYCLES = 60;
    localparam int      CYCLE_LIMIT  = 400000;
    localparam int      SEGMENTS     = 9;
    localparam int      SEG_ITEMS    = 100;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [tpid_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [tpid_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    tpid_pkg::t_in                   i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    tpid_pkg::t_out                  o_out_data;

    temperature_pid_step #(.FRAC_BITS(FRAC)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    logic signed [15:0] set_temp = '0;
    logic [15:0]        gain_p   = '0;
    logic [15:0]        gain_i   = '0;
    logic [15:0]        gain_d   = '0;
    longint             integ_acc  = 0;
    longint             prev_error = 0;

    tpid_pkg::t_out expected_duty_q[$];
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count     = 0;
    int   cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        tpid_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_duty_q.size() == 0) begin
                $error("duty: expected none, got %0d", o_out_data.duty);
                fail_count++;
            end else begin
                want = expected_duty_q.pop_front();
                if (o_out_data.duty !== want.duty) begin
                    $error("duty: expected %0d, got %0d", want.duty, o_out_data.duty);
                    fail_count++;
                end
                if (o_out_data.pwm_level !== want.pwm_level) begin
                    $error("pwm_level: expected %0d, got %0d", want.pwm_level,
                           o_out_data.pwm_level);
                    fail_count++;
                end
            end
        end
    end

    function automatic tpid_pkg::t_out pid_duty(tpid_pkg::t_in smp);
        longint         err, p_term, i_term, d_term, pid_sum, whole, ms;
        tpid_pkg::t_out res;
        err = longint'(set_temp) - longint'($signed(smp.temperature))
            + (TEMP_OFFSET <<< FRAC);
        ms  = longint'(smp.elapsed_ms);
        p_term = (longint'(gain_p) * err * PCT_MUL) >>> PCT_SHIFT;
        i_term = ((integ_acc * PCT_MUL) >>> PCT_SHIFT) + longint'(gain_i) * err;
        if (i_term > INTEG_HI) i_term = INTEG_HI;
        if (i_term < INTEG_LO) i_term = INTEG_LO;
        integ_acc = i_term;
        d_term = 0;
        if (ms != 0)
            d_term = (DERIV_GAIN * longint'(gain_d) * (err - prev_error)) / ms;
        prev_error = err;
        pid_sum = p_term + i_term + d_term;
        if (pid_sum < 0) begin
            whole = 0;
        end else begin
            whole = pid_sum >>> (2 * FRAC);
            if (whole > DUTY_TOP) whole = DUTY_TOP;
        end
        res.duty      = 8'(whole);
        res.pwm_level = 8'(DUTY_TOP - whole);
        return res;
    endfunction

    task automatic send_sample(input logic signed [15:0] temp, input logic [15:0] ms);
        tpid_pkg::t_in smp;
        smp.temperature = temp;
        smp.elapsed_ms  = ms;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        expected_duty_q.push_back(pid_duty(smp));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_duty_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] sp, kp, ki, kd);
        logic [15:0]                    vals [4];
        logic [tpid_pkg::CFG_IDX_W-1:0] idxs [4];
        settle();
        vals = '{sp, kp, ki, kd};
        idxs = '{tpid_pkg::CFG_SETPOINT, tpid_pkg::CFG_KP, tpid_pkg::CFG_KI,
                 tpid_pkg::CFG_KD};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        set_temp = sp;
        gain_p   = kp;
        gain_i   = ki;
        gain_d   = kd;
    endtask

    task automatic set_idling(input int phase);
        unique case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 6)  return 16'($urandom_range(0, 8191));
        return 16'($urandom);
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'sd0, 16'd0);
        send_sample(-16'sd32768, 16'hFFFF);
    endtask

    task automatic test_field_extremes();
        apply_settings(16'd0, 16'd256, 16'd1, 16'd256);
        send_sample(16'sd32767, 16'd1);
        send_sample(-16'sd32768, 16'hFFFF);
        send_sample(16'sd0, 16'd0);
        send_sample(16'sd32767, 16'hFFFF);
    endtask

    task automatic test_duty_clamp();
        apply_settings(16'h7FFF, 16'hFFFF, 16'd0, 16'd0);
        send_sample(-16'sd32768, 16'd10);
        apply_settings(16'h8000, 16'hFFFF, 16'd0, 16'd0);
        send_sample(16'sd32767, 16'd10);
        apply_settings(16'd0, 16'd25600, 16'd0, 16'd0);
        send_sample(16'sd0, 16'd10);
    endtask

    task automatic test_zero_elapsed();
        apply_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'sd0, 16'd1);
        send_sample(-16'sd5000, 16'd0);
        send_sample(16'sd5000, 16'd0);
        send_sample(16'sd5000, 16'd1);
        send_sample(-16'sd32768, 16'd1);
        send_sample(16'sd32767, 16'd1);
    endtask

    task automatic test_integral_leak();
        apply_settings(16'h7FFF, 16'd0, 16'hFFFF, 16'd0);
        repeat (4) send_sample(-16'sd32768, 16'd100);
        apply_settings(16'h8000, 16'd0, 16'hFFFF, 16'd0);
        repeat (3) send_sample(16'sd32767, 16'd100);
    endtask

    task automatic test_random_tracking();
        logic signed [15:0] temp;
        logic [15:0]        ms;
        logic [15:0]        sp;
        int                 r;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            sp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25600));
            if (seg == 0)
                apply_settings(16'h8000, 16'd0, 16'd0, 16'd0);
            else if (seg == SEGMENTS - 1)
                apply_settings(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                apply_settings(sp, pick_gain(), pick_gain(), pick_gain());
            set_idling(seg % 4);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                r = $urandom_range(9);
                if (r < 2) begin
                    temp = 16'($urandom);
                    ms   = 16'($urandom);
                end else if (r == 9) begin
                    temp = 16'($urandom);
                    ms   = 16'd0;
                end else begin
                    temp = set_temp + 16'($urandom_range(0, 4095)) - 16'sd2048;
                    ms   = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
                end
                send_sample(temp, ms);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_duty_clamp();
        test_zero_elapsed();
        test_integral_leak();
        test_random_tracking();
        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
